### sv/mrf_pkg.sv
package mrf_pkg;

  localparam int MAX_DIM    = 64;
  localparam int DIM_W      = 6;
  localparam int SIZE_W     = 7;
  localparam int DATA_W     = 32;
  localparam int MODE_W     = 2;
  localparam int OP_W       = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam int DEPTH      = MAX_DIM * MAX_DIM;
  localparam int ADDR_W     = $clog2(DEPTH);

  localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_XFORM = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

  localparam logic [OP_W-1:0] OP_VFLIP    = 3'd0;
  localparam logic [OP_W-1:0] OP_HFLIP    = 3'd1;
  localparam logic [OP_W-1:0] OP_ROT_R    = 3'd2;
  localparam logic [OP_W-1:0] OP_ROT_L    = 3'd3;
  localparam logic [OP_W-1:0] OP_QUAD_CW  = 3'd4;
  localparam logic [OP_W-1:0] OP_QUAD_CCW = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS = 2'd1;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(64);
  localparam logic [SIZE_W-1:0] DIM_LIMIT  = SIZE_W'(MAX_DIM & ~1);
  localparam logic [SIZE_W-1:0] DIM_FULL   = SIZE_W'(MAX_DIM);

  typedef struct packed {
    logic [DIM_W-1:0] r;
    logic [DIM_W-1:0] c;
  } cell_t;

  typedef struct packed {
    logic [SIZE_W-1:0] n;
    logic [SIZE_W-1:0] m;
  } size_pair_t;

  // transform request from the front end to the sequencer
  typedef struct packed {
    logic              start;
    logic [OP_W-1:0]   op;
    logic [SIZE_W-1:0] n;
    logic [SIZE_W-1:0] m;
  } xf_req_t;

  // memory strobes and status from the sequencer
  typedef struct packed {
    logic              idle;
    logic              done;
    logic              rot;
    logic              mat_re;
    logic [ADDR_W-1:0] mat_raddr;
    logic              mat_we;
    logic              mat_zero;
    logic [ADDR_W-1:0] mat_waddr;
    logic              scr_re;
    logic [ADDR_W-1:0] scr_raddr;
    logic              scr_we;
    logic [ADDR_W-1:0] scr_waddr;
  } xf_ctl_t;

  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] reg_val);
    logic [SIZE_W-1:0] s;
    s = {reg_val[SIZE_W-1:1], 1'b0};
    return (s > DIM_LIMIT) ? DIM_LIMIT : s;
  endfunction

  function automatic size_pair_t cur_size(input logic t,
                                          input logic [SIZE_W-1:0] rows,
                                          input logic [SIZE_W-1:0] cols);
    size_pair_t sp;
    sp.n = t ? eff_size(cols) : eff_size(rows);
    sp.m = t ? eff_size(rows) : eff_size(cols);
    return sp;
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [DIM_W-1:0] r,
                                                  input logic [DIM_W-1:0] c);
    return ADDR_W'(r) * ADDR_W'(MAX_DIM) + ADDR_W'(c);
  endfunction

  // destination of source element (i, j) under one transform
  function automatic cell_t xform_dest(input logic [OP_W-1:0]   op,
                                       input logic [DIM_W-1:0]  i,
                                       input logic [DIM_W-1:0]  j,
                                       input logic [SIZE_W-1:0] n,
                                       input logic [SIZE_W-1:0] m);
    cell_t             d;
    logic [SIZE_W-1:0] h;
    logic [SIZE_W-1:0] w;
    logic [SIZE_W-1:0] ie;
    logic [SIZE_W-1:0] je;
    logic              ilo;
    logic              jlo;
    h   = n >> 1;
    w   = m >> 1;
    ie  = {1'b0, i};
    je  = {1'b0, j};
    ilo = ie < h;
    jlo = je < w;
    d.r = i;
    d.c = j;
    case (op)
      OP_VFLIP: begin
        d.r = DIM_W'(n - SIZE_W'(1) - ie);
      end
      OP_HFLIP: begin
        d.c = DIM_W'(m - SIZE_W'(1) - je);
      end
      OP_ROT_R: begin
        d.r = j;
        d.c = DIM_W'(n - SIZE_W'(1) - ie);
      end
      OP_ROT_L: begin
        d.r = DIM_W'(m - SIZE_W'(1) - je);
        d.c = i;
      end
      OP_QUAD_CW: begin
        if (ilo && jlo) d.c = DIM_W'(je + w);
        else if (ilo)   d.r = DIM_W'(ie + h);
        else if (!jlo)  d.c = DIM_W'(je - w);
        else            d.r = DIM_W'(ie - h);
      end
      OP_QUAD_CCW: begin
        if (ilo && jlo) d.r = DIM_W'(ie + h);
        else if (ilo)   d.c = DIM_W'(je - w);
        else if (!jlo)  d.r = DIM_W'(ie - h);
        else            d.c = DIM_W'(je + w);
      end
      default: begin
        d.r = i;
        d.c = j;
      end
    endcase
    return d;
  endfunction

endpackage

### sv/mrf_in_if.sv
interface mrf_in_if import mrf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [DIM_W-1:0]  row;
  logic [DIM_W-1:0]  col;
  logic [DATA_W-1:0] value;
  logic [OP_W-1:0]   op;

  modport source (output valid, output mode, output row, output col, output value,
                  output op, input ready);
  modport sink   (input valid, input mode, input row, input col, input value,
                  input op, output ready);
endinterface

### sv/mrf_out_if.sv
interface mrf_out_if import mrf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_value;
  logic [SIZE_W-1:0] cur_rows;
  logic [SIZE_W-1:0] cur_cols;
  logic              addr_error;

  modport source (output valid, output read_value, output cur_rows, output cur_cols,
                  output addr_error, input ready);
  modport sink   (input valid, input read_value, input cur_rows, input cur_cols,
                  input addr_error, output ready);
endinterface

### sv/mrf_cfg_if.sv
interface mrf_cfg_if import mrf_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### sv/mrf_ram.sv
module mrf_ram #(
  parameter int AW = 12,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem_r [0:(1<<AW)-1];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // hold last read word when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### sv/mrf_ctrl.sv
module mrf_ctrl import mrf_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  xf_req_t req,
  output xf_ctl_t ctl
);

  typedef enum logic [6:0] {
    S_CLEAR    = 7'b0000001,
    S_IDLE     = 7'b0000010,
    S_P1       = 7'b0000100,
    S_P1_DRAIN = 7'b0001000,
    S_P2       = 7'b0010000,
    S_P2_DRAIN = 7'b0100000,
    S_DONE     = 7'b1000000
  } state_t;

  state_t            state_r, state_nxt;
  logic [DIM_W-1:0]  i_r, i_nxt;
  logic [DIM_W-1:0]  j_r, j_nxt;
  logic [SIZE_W-1:0] n_r, n_nxt;
  logic [SIZE_W-1:0] m_r, m_nxt;
  logic [OP_W-1:0]   op_r, op_nxt;
  logic              rot_r, rot_nxt;
  logic              wv_r, wv_nxt;
  logic [ADDR_W-1:0] dst_r, dst_nxt;

  logic [SIZE_W-1:0] bound_n;
  logic [SIZE_W-1:0] bound_m;
  logic              last_i;
  logic              last_j;
  logic [DIM_W-1:0]  i_step;
  logic [DIM_W-1:0]  j_step;
  logic [ADDR_W-1:0] cur_addr;
  cell_t             dest;
  logic              xf_ok;
  logic              req_rot;

  always_comb begin
    bound_n  = (state_r == S_CLEAR) ? DIM_FULL : n_r;
    bound_m  = (state_r == S_CLEAR) ? DIM_FULL : m_r;
    last_i   = {1'b0, i_r} == SIZE_W'(bound_n - SIZE_W'(1));
    last_j   = {1'b0, j_r} == SIZE_W'(bound_m - SIZE_W'(1));
    j_step   = last_j ? '0 : DIM_W'(j_r + DIM_W'(1));
    i_step   = last_j ? DIM_W'(i_r + DIM_W'(1)) : i_r;
    cur_addr = cell_addr(i_r, j_r);
    dest     = xform_dest(op_r, i_r, j_r, n_r, m_r);
    xf_ok    = (req.op <= OP_QUAD_CCW) && (req.n != '0) && (req.m != '0);
    req_rot  = (req.op == OP_ROT_R) || (req.op == OP_ROT_L);
  end

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    n_nxt     = n_r;
    m_nxt     = m_r;
    op_nxt    = op_r;
    rot_nxt   = rot_r;
    wv_nxt    = wv_r;
    dst_nxt   = dst_r;
    case (state_r)
      S_CLEAR: begin
        i_nxt = i_step;
        j_nxt = j_step;
        if (last_i && last_j) begin
          i_nxt     = '0;
          j_nxt     = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req.start) begin
          n_nxt  = req.n;
          m_nxt  = req.m;
          op_nxt = req.op;
          i_nxt  = '0;
          j_nxt  = '0;
          wv_nxt = 1'b0;
          if (xf_ok) begin
            rot_nxt   = req_rot;
            state_nxt = S_P1;
          end else begin
            rot_nxt   = 1'b0;
            state_nxt = S_DONE;
          end
        end
      end
      S_P1: begin
        wv_nxt  = 1'b1;
        dst_nxt = cell_addr(dest.r, dest.c);
        i_nxt   = i_step;
        j_nxt   = j_step;
        if (last_i && last_j) begin
          i_nxt     = '0;
          j_nxt     = '0;
          state_nxt = S_P1_DRAIN;
          // copy-back covers the rotated shape
          if (rot_r) begin
            n_nxt = m_r;
            m_nxt = n_r;
          end
        end
      end
      S_P1_DRAIN: begin
        wv_nxt    = 1'b0;
        state_nxt = S_P2;
      end
      S_P2: begin
        wv_nxt  = 1'b1;
        dst_nxt = cur_addr;
        i_nxt   = i_step;
        j_nxt   = j_step;
        if (last_i && last_j) begin
          state_nxt = S_P2_DRAIN;
        end
      end
      S_P2_DRAIN: begin
        wv_nxt    = 1'b0;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      i_r     <= '0;
      j_r     <= '0;
      rot_r   <= 1'b0;
      wv_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      rot_r   <= rot_nxt;
      wv_r    <= wv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r   <= n_nxt;
    m_r   <= m_nxt;
    op_r  <= op_nxt;
    dst_r <= dst_nxt;
  end

  always_comb begin
    ctl.idle      = state_r == S_IDLE;
    ctl.done      = state_r == S_DONE;
    ctl.rot       = (state_r == S_DONE) && rot_r;
    ctl.mat_re    = state_r == S_P1;
    ctl.mat_raddr = cur_addr;
    ctl.mat_zero  = state_r == S_CLEAR;
    ctl.mat_we    = (state_r == S_CLEAR) ||
                    (wv_r && ((state_r == S_P2) || (state_r == S_P2_DRAIN)));
    ctl.mat_waddr = (state_r == S_CLEAR) ? cur_addr : dst_r;
    ctl.scr_re    = state_r == S_P2;
    ctl.scr_raddr = cur_addr;
    ctl.scr_we    = wv_r && ((state_r == S_P1) || (state_r == S_P1_DRAIN));
    ctl.scr_waddr = dst_r;
  end

endmodule

### sv/matrix_rotate_flip_engine.sv
// Matrix rotate and flip engine.
// Holds a matrix of 32-bit words of up to 64 x 64 elements. Each word on the
// in_ch channel writes one element, reads one element, or applies a
// whole-matrix transform (flips, rotations, quadrant moves); each gives
// exactly one result word on out_ch with the read data, the current size and
// an address error flag. cfg_ch sets the loaded row and column counts and is
// always ready; write it only while no item is in flight.
// Element writes and reads are accepted one per cycle while out_ch does not
// stall; each result is registered in stage s1, then in the out stage. A
// transform runs two passes over the current n x m region, one word per cycle
// through the single read port of each store (matrix to scratch, then back),
// and its result enters s1 once the sequencer is done; an unknown op or an
// empty region skips both passes. No item is accepted while a transform runs.
// After reset the matrix store is cleared one word per cycle: in_ch stays not
// ready until the whole store is cleared, config writes are taken as usual.
// When out_ch stalls, one further element item is still accepted and held in
// the first result stage (s1); after that in_ch drops ready until out_ch moves.
module matrix_rotate_flip_engine import mrf_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  mrf_in_if.sink    in_ch,
  mrf_out_if.source out_ch,
  mrf_cfg_if.sink   cfg_ch
);

  logic [SIZE_W-1:0] rows_r, rows_nxt;
  logic [SIZE_W-1:0] cols_r, cols_nxt;
  logic              transposed_r, transposed_nxt;

  logic              s1_v_r, s1_v_nxt;
  logic              s1_rd_r, s1_rd_nxt;
  logic              s1_err_r, s1_err_nxt;
  logic [SIZE_W-1:0] s1_n_r, s1_n_nxt;
  logic [SIZE_W-1:0] s1_m_r, s1_m_nxt;

  logic              out_v_r, out_v_nxt;
  logic [DATA_W-1:0] out_rv_r, out_rv_nxt;
  logic              out_err_r, out_err_nxt;
  logic [SIZE_W-1:0] out_n_r, out_n_nxt;
  logic [SIZE_W-1:0] out_m_r, out_m_nxt;

  size_pair_t        cur;
  size_pair_t        post;
  logic              in_range;
  logic              out_free;
  logic              s1_free;
  logic              acc;
  logic              is_elem;
  logic              elem_we;
  logic              elem_re;
  logic [ADDR_W-1:0] elem_addr;

  xf_req_t           req;
  xf_ctl_t           ctl;

  logic              mat_we;
  logic [ADDR_W-1:0] mat_waddr;
  logic [DATA_W-1:0] mat_wdata;
  logic              mat_re;
  logic [ADDR_W-1:0] mat_raddr;
  logic [DATA_W-1:0] mat_rdata;
  logic [DATA_W-1:0] scr_rdata;

  always_comb begin
    cur       = cur_size(transposed_r, rows_r, cols_r);
    post      = cur_size(transposed_nxt, rows_r, cols_r);
    in_range  = ({1'b0, in_ch.row} < cur.n) && ({1'b0, in_ch.col} < cur.m);
    is_elem   = (in_ch.mode == MODE_WRITE) || (in_ch.mode == MODE_READ);
    out_free  = !out_v_r || out_ch.ready;
    s1_free   = !s1_v_r || out_free;
    // a transform reuses the matrix read port, so it waits for an empty stage
    in_ch.ready = ctl.idle && ((in_ch.mode == MODE_XFORM) ? !s1_v_r : s1_free);
    acc       = in_ch.valid && in_ch.ready;
    elem_we   = acc && (in_ch.mode == MODE_WRITE) && in_range;
    elem_re   = acc && (in_ch.mode == MODE_READ) && in_range;
    elem_addr = cell_addr(in_ch.row, in_ch.col);
    req.start = acc && (in_ch.mode == MODE_XFORM);
    req.op    = in_ch.op;
    req.n     = cur.n;
    req.m     = cur.m;
  end

  mrf_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .ctl   (ctl)
  );

  always_comb begin
    mat_we    = ctl.mat_we || elem_we;
    mat_waddr = elem_we ? elem_addr : ctl.mat_waddr;
    mat_wdata = elem_we ? in_ch.value : (ctl.mat_zero ? '0 : scr_rdata);
    mat_re    = ctl.mat_re || elem_re;
    mat_raddr = elem_re ? elem_addr : ctl.mat_raddr;
  end

  mrf_ram #(.AW(ADDR_W), .DW(DATA_W)) u_mat_ram (
    .clk   (clk),
    .we    (mat_we),
    .waddr (mat_waddr),
    .wdata (mat_wdata),
    .re    (mat_re),
    .raddr (mat_raddr),
    .rdata (mat_rdata)
  );

  mrf_ram #(.AW(ADDR_W), .DW(DATA_W)) u_scr_ram (
    .clk   (clk),
    .we    (ctl.scr_we),
    .waddr (ctl.scr_waddr),
    .wdata (mat_rdata),
    .re    (ctl.scr_re),
    .raddr (ctl.scr_raddr),
    .rdata (scr_rdata)
  );

  // config registers and orientation
  always_comb begin
    rows_nxt       = rows_r;
    cols_nxt       = cols_r;
    transposed_nxt = transposed_r ^ ctl.rot;
    if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        CFG_NUM_ROWS: rows_nxt = SIZE_W'(cfg_ch.data);
        CFG_NUM_COLS: cols_nxt = SIZE_W'(cfg_ch.data);
        default:      ;
      endcase
    end
  end

  assign cfg_ch.ready = 1'b1;

  // result stages: s1 waits on the RAM read, out faces the receiver
  always_comb begin
    s1_v_nxt   = s1_v_r;
    s1_rd_nxt  = s1_rd_r;
    s1_err_nxt = s1_err_r;
    s1_n_nxt   = s1_n_r;
    s1_m_nxt   = s1_m_r;
    if (s1_v_r && out_free) begin
      s1_v_nxt = 1'b0;
    end
    if (acc && (in_ch.mode != MODE_XFORM)) begin
      s1_v_nxt   = 1'b1;
      s1_rd_nxt  = elem_re;
      s1_err_nxt = is_elem && !in_range;
      s1_n_nxt   = cur.n;
      s1_m_nxt   = cur.m;
    end else if (ctl.done) begin
      s1_v_nxt   = 1'b1;
      s1_rd_nxt  = 1'b0;
      s1_err_nxt = 1'b0;
      s1_n_nxt   = post.n;
      s1_m_nxt   = post.m;
    end
  end

  always_comb begin
    out_v_nxt   = out_v_r;
    out_rv_nxt  = out_rv_r;
    out_err_nxt = out_err_r;
    out_n_nxt   = out_n_r;
    out_m_nxt   = out_m_r;
    if (out_free) begin
      out_v_nxt   = s1_v_r;
      out_rv_nxt  = s1_rd_r ? mat_rdata : '0;
      out_err_nxt = s1_err_r;
      out_n_nxt   = s1_n_r;
      out_m_nxt   = s1_m_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r       <= SIZE_RESET;
      cols_r       <= SIZE_RESET;
      transposed_r <= 1'b0;
      s1_v_r       <= 1'b0;
      out_v_r      <= 1'b0;
    end else begin
      rows_r       <= rows_nxt;
      cols_r       <= cols_nxt;
      transposed_r <= transposed_nxt;
      s1_v_r       <= s1_v_nxt;
      out_v_r      <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_rd_r   <= s1_rd_nxt;
    s1_err_r  <= s1_err_nxt;
    s1_n_r    <= s1_n_nxt;
    s1_m_r    <= s1_m_nxt;
    out_rv_r  <= out_rv_nxt;
    out_err_r <= out_err_nxt;
    out_n_r   <= out_n_nxt;
    out_m_r   <= out_m_nxt;
  end

  assign out_ch.valid      = out_v_r;
  assign out_ch.read_value = out_rv_r;
  assign out_ch.addr_error = out_err_r;
  assign out_ch.cur_rows   = out_n_r;
  assign out_ch.cur_cols   = out_m_r;

  // a finished transform must find the first result stage empty
  assert property (@(posedge clk) disable iff (!rst_n) ctl.done |-> !s1_v_r)
    else $error("transform result collides with pending result");

  // sequencer and element traffic never share the matrix ports
  assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.mat_we || ctl.mat_re) |-> !(elem_we || elem_re))
    else $error("matrix port conflict");

  // the matrix read data must not be overwritten under a pending read result
  assert property (@(posedge clk) disable iff (!rst_n) ctl.mat_re |-> !s1_v_r)
    else $error("transform read while element result pending");

  // orientation flips only as a rotation completes
  assert property (@(posedge clk) disable iff (!rst_n)
    (transposed_r != $past(transposed_r)) |-> $past(ctl.rot))
    else $error("orientation changed outside a rotation");

endmodule
